@@ hw/rtl/ptmr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptmr_pkg
// Shared types and constants of the positivity timestep min-reduce block.
// ----------------------------------------------------------------------------
package ptmr_pkg;

	localparam int CELL_BITS  = 20;              // reported index width
	localparam int CNT_BITS   = CELL_BITS + 1;   // sweep counter, saturates at 2**CELL_BITS
	localparam int SAFE_BITS  = 17;
	localparam int VAL_BITS   = 32;
	localparam int SA_BITS    = SAFE_BITS + VAL_BITS;    // safety * area
	localparam int PROD_BITS  = SA_BITS + VAL_BITS;      // safety * area * depth
	localparam int FRAC_SHIFT = 8;                       // Q24.8 area scaling
	localparam int STEP_BITS  = 5;
	localparam int SA_STEPS   = SAFE_BITS;
	localparam int D_STEPS    = VAL_BITS;
	localparam int DIV_STEPS  = VAL_BITS;

	localparam logic [SAFE_BITS-1:0] SAFETY_ONE = 17'd65536;
	localparam logic [VAL_BITS-1:0]  TS_LIMIT   = '1;

	localparam int IN_BITS  = 96;
	localparam int OUT_BITS = 80;

	localparam logic [2:0] REG_SAFETY_ADDR = 3'd0;

	typedef logic [2:0] status_t;
	localparam status_t STAT_OK          = 3'd0;
	localparam status_t STAT_NEG_OUTFLOW = 3'd1;
	localparam status_t STAT_DRY_OUTFLOW = 3'd2;
	localparam status_t STAT_INCOMPAT    = 3'd3;
	localparam status_t STAT_SAFETY      = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_SA,
		ST_MUL_D,
		ST_RANGE,
		ST_DIV,
		ST_UPDATE,
		ST_FINISH
	} state_t;

endpackage

@@ hw/rtl/positivity_timestep_min_reduce_top.sv @@
// ----------------------------------------------------------------------------
// positivity_timestep_min_reduce_top
// Bit-serial timestep limit safety*area*depth/outflow, min-reduced per sweep.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  tdata: cell_area, water_depth,
//                                      outgoing_rate; tlast: last_cell
//  m_*       out  m_tvalid / m_tready  tdata: timestep, has_timestep,
//                                      limit_cell, status, error_cell
//  apb       in   psel / penable       reg 0 @ 0x0: safety scale
//
//  A cell with a timestep to compute runs, from accept to accept: 17
//  shift-add steps for safety*area, 32 for the depth product, one range
//  check, 32 restoring division steps, update, finish and idle; an
//  overflowing quotient skips the division. A skipped or faulty cell goes
//  straight from idle to finish. A new cell is taken only in idle. The
//  result sits in an output register; a last cell stalls only while the
//  previous result waits. Reset is asynchronous.
// ----------------------------------------------------------------------------
module positivity_timestep_min_reduce_top
	import ptmr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_BITS-1:0]  s_tdata,   // cell_area, water_depth, outgoing_rate
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata,   // timestep, has_timestep,
	                                       // limit_cell, status, error_cell, pad
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	state_t state_q, state_nxt;

	logic [SAFE_BITS-1:0] safety_q;
	logic [VAL_BITS-1:0]  min_q;
	logic                 have_q;
	logic [CELL_BITS-1:0] best_q;
	logic [CNT_BITS-1:0]  cell_cnt_q;
	status_t              err_q;
	logic [CELL_BITS-1:0] err_idx_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 last_q;
	logic                 m_tvalid_q;

	logic [VAL_BITS-1:0]  area_q;
	logic [VAL_BITS-1:0]  depth_q;
	logic [VAL_BITS-1:0]  rate_q;
	logic [CELL_BITS-1:0] idx_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [SA_BITS-1:0]   mcand_q;
	logic [VAL_BITS-1:0]  rem_q;
	logic [VAL_BITS-1:0]  quo_q;
	logic [OUT_BITS-1:0]  out_q;

	logic [VAL_BITS-1:0] in_area, in_depth, in_rate;
	logic                accept, cfg_wr;
	logic                safety_bad, go_mul, chk_err;
	status_t             chk_code;
	logic                sa_done, d_done, div_done, out_free, out_load;
	logic                range_sat;
	logic [VAL_BITS:0]   sum_a;
	logic [SA_BITS:0]    sum_b;
	logic [VAL_BITS-1:0] div_shift;
	logic [VAL_BITS:0]   div_diff;
	logic [PROD_BITS-1:0] sa_next, d_next;

	assign in_area  = s_tdata[31:0];
	assign in_depth = s_tdata[63:32];
	assign in_rate  = s_tdata[95:64];

	assign cfg_wr = psel & penable & pwrite & pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SAFETY_ADDR[2]) ?
		{{(32-SAFE_BITS){1'b0}}, safety_q} : 32'd0;

	// per-cell checks, in priority order
	assign safety_bad = (safety_q == '0) || (safety_q > SAFETY_ONE);
	always_comb begin
		chk_err  = 1'b1;
		chk_code = STAT_OK;
		go_mul   = 1'b0;
		if (safety_bad) begin
			chk_code = STAT_SAFETY;
		end else if (cell_cnt_q[CNT_BITS-1]) begin
			chk_code = STAT_INCOMPAT;
		end else if (in_area == '0) begin
			chk_code = STAT_INCOMPAT;
		end else if (in_rate[VAL_BITS-1]) begin
			chk_code = STAT_NEG_OUTFLOW;
		end else if (in_depth[VAL_BITS-1]) begin
			chk_code = STAT_INCOMPAT;
		end else if (in_rate == '0) begin
			chk_err = 1'b0;
		end else if (in_depth == '0) begin
			chk_code = STAT_DRY_OUTFLOW;
		end else begin
			chk_err = 1'b0;
			go_mul  = (err_q == STAT_OK);
		end
		if (err_q != STAT_OK) begin
			chk_err = 1'b0;
		end
	end

	// shift-add and restore-divide steps
	assign sum_a   = {1'b0, prod_q[SA_BITS-1:SAFE_BITS]} +
		(prod_q[0] ? {1'b0, area_q} : '0);
	assign sa_next = {{(PROD_BITS-SA_BITS){1'b0}}, sum_a, prod_q[SAFE_BITS-1:1]};
	assign sum_b   = {1'b0, prod_q[PROD_BITS-1:VAL_BITS]} +
		(prod_q[0] ? {1'b0, mcand_q} : '0);
	assign d_next  = {sum_b, prod_q[VAL_BITS-1:1]};
	assign div_shift = {rem_q[VAL_BITS-2:0], quo_q[VAL_BITS-1]};
	assign div_diff  = {1'b0, div_shift} - {1'b0, rate_q};

	// N/256 >= rate * 2^32 means the quotient overflows 32 bits
	assign range_sat = prod_q[PROD_BITS-1:VAL_BITS+FRAC_SHIFT] >=
		{{(PROD_BITS-2*VAL_BITS-FRAC_SHIFT){1'b0}}, rate_q};

	assign sa_done  = (step_q == STEP_BITS'(SA_STEPS - 1));
	assign d_done   = (step_q == STEP_BITS'(D_STEPS - 1));
	assign div_done = (step_q == STEP_BITS'(DIV_STEPS - 1));
	assign out_free = ~m_tvalid_q | m_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = go_mul ? ST_MUL_SA : ST_FINISH;
				end
			end
			ST_MUL_SA: begin
				if (sa_done) begin
					state_nxt = ST_MUL_D;
				end
			end
			ST_MUL_D: begin
				if (d_done) begin
					state_nxt = ST_RANGE;
				end
			end
			ST_RANGE: begin
				state_nxt = range_sat ? ST_UPDATE : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!last_q || out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_FINISH: begin
				out_load = last_q & out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			safety_q   <= SAFETY_ONE;
			min_q      <= '1;
			have_q     <= 1'b0;
			best_q     <= '0;
			cell_cnt_q <= '0;
			err_q      <= STAT_OK;
			err_idx_q  <= '0;
			step_q     <= '0;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr && paddr[2] == REG_SAFETY_ADDR[2]) begin
				safety_q <= pwdata[SAFE_BITS-1:0];
			end
			if (state_q != state_nxt) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
			if (accept) begin
				last_q <= s_tlast;
				if (!cell_cnt_q[CNT_BITS-1]) begin
					cell_cnt_q <= cell_cnt_q + 1'b1;
				end
				if (chk_err) begin
					err_q     <= chk_code;
					err_idx_q <= cell_cnt_q[CELL_BITS-1:0];
				end
			end
			if (state_q == ST_UPDATE) begin
				if (quo_q == '0) begin
					err_q     <= STAT_INCOMPAT;
					err_idx_q <= idx_q;
				end else if (!have_q || quo_q < min_q) begin
					min_q  <= quo_q;
					best_q <= idx_q;
					have_q <= 1'b1;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				min_q      <= '1;
				have_q     <= 1'b0;
				best_q     <= '0;
				cell_cnt_q <= '0;
				err_q      <= STAT_OK;
				err_idx_q  <= '0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			area_q  <= in_area;
			depth_q <= in_depth;
			rate_q  <= in_rate;
			idx_q   <= cell_cnt_q[CELL_BITS-1:0];
			prod_q  <= {{(PROD_BITS-SAFE_BITS){1'b0}}, safety_q};
		end
		case (state_q)
			ST_MUL_SA: begin
				if (sa_done) begin
					mcand_q <= sa_next[SA_BITS-1:0];
					prod_q  <= {{(PROD_BITS-VAL_BITS){1'b0}}, depth_q};
				end else begin
					prod_q <= sa_next;
				end
			end
			ST_MUL_D: begin
				prod_q <= d_next;
			end
			ST_RANGE: begin
				if (range_sat) begin
					quo_q <= TS_LIMIT;
				end else begin
					rem_q <= prod_q[2*VAL_BITS+FRAC_SHIFT-1:VAL_BITS+FRAC_SHIFT];
					quo_q <= prod_q[VAL_BITS+FRAC_SHIFT-1:FRAC_SHIFT];
				end
			end
			ST_DIV: begin
				if (!div_diff[VAL_BITS]) begin
					rem_q <= div_diff[VAL_BITS-1:0];
					quo_q <= {quo_q[VAL_BITS-2:0], 1'b1};
				end else begin
					rem_q <= div_shift;
					quo_q <= {quo_q[VAL_BITS-2:0], 1'b0};
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
		if (out_load) begin
			if (err_q != STAT_OK) begin
				out_q <= {4'b0, err_idx_q, err_q, {CELL_BITS{1'b0}}, 1'b0,
					{VAL_BITS{1'b0}}};
			end else begin
				out_q <= {4'b0, {CELL_BITS{1'b0}}, STAT_OK,
					have_q ? best_q : {CELL_BITS{1'b0}}, have_q,
					have_q ? min_q : {VAL_BITS{1'b0}}};
			end
		end
	end

endmodule
